/* src/cpu_alu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_pkg
// Shared types and operation codes for the 8/16-bit CPU ALU with flags.
// ----------------------------------------------------------------------------
package cpu_alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_XOR    = 5'd5,
    OP_OR     = 5'd6,
    OP_CP     = 5'd7,
    OP_INC    = 5'd8,
    OP_DEC    = 5'd9,
    OP_RLC    = 5'd10,
    OP_RRC    = 5'd11,
    OP_RL     = 5'd12,
    OP_RR     = 5'd13,
    OP_SLA    = 5'd14,
    OP_SRA    = 5'd15,
    OP_SRL    = 5'd16,
    OP_SWAP   = 5'd17,
    OP_DAA    = 5'd18,
    OP_CPL    = 5'd19,
    OP_SCF    = 5'd20,
    OP_CCF    = 5'd21,
    OP_BIT    = 5'd22,
    OP_SET    = 5'd23,
    OP_RES    = 5'd24,
    OP_ADD16  = 5'd25,
    OP_ADDSP  = 5'd26,
    OP_INC16  = 5'd27,
    OP_DEC16  = 5'd28
  } alu_op_t;

  localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
  localparam logic [7:0] DAA_HI_LIM  = 8'h99;
  localparam logic [3:0] DAA_LO_LIM  = 4'h9;

  typedef struct packed {
    logic [4:0]  op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        zero_in;
    logic        subtract_in;
    logic        half_in;
    logic        carry_in;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_out;
    logic        carry_out;
  } alu_out_t;

endpackage
`default_nettype wire

/* src/cpu_alu_with_flags.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// Handheld-console CPU ALU: 8-bit arithmetic, logic, rotate, shift, bit and
// daa operations, plus 16-bit add, signed-offset add, inc and dec, with the
// four flags Z, N, H and C.
// ----------------------------------------------------------------------------
// One operation is taken per clock: busy stays low, so every cycle with start
// high accepts a beat. The beat is captured in an input register, evaluated
// by single-pass combinational logic and captured in the result register, so
// its result appears with done high once it has passed both registers, and
// is shown for one cycle only; the receiver must take it then. Results come
// out in acceptance order, one per accepted beat.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire cpu_alu_pkg::alu_in_t operation,
  output logic                  done,
  output cpu_alu_pkg::alu_out_t outcome
);

  logic                  in_valid;
  cpu_alu_pkg::alu_in_t  in_q;
  cpu_alu_pkg::alu_out_t outcome_next;

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [15:0] aw;
  logic [15:0] bw;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  diff9;
  logic [4:0]  diff_lo;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [16:0] sum17;
  logic [12:0] sum12;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_adj;
  logic [15:0] r;
  logic        z;
  logic        n;
  logic        h;
  logic        c;
  logic        setz;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
      done     <= in_valid;
    end
    if (start & ~busy) begin
      in_q <= operation;
    end
    outcome <= outcome_next;
  end

  assign aw      = in_q.operand_a;
  assign bw      = in_q.operand_b;
  assign a8      = aw[7:0];
  assign b8      = bw[7:0];
  assign cin     = (in_q.op == cpu_alu_pkg::OP_ADC || in_q.op == cpu_alu_pkg::OP_SBC)
                   & in_q.carry_in;
  assign sum9    = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
  assign sum_lo  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
  assign diff9   = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
  assign diff_lo = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
  assign inc8    = a8 + 8'd1;
  assign dec8    = a8 - 8'd1;
  assign sum17   = {1'b0, aw} + {1'b0, bw};
  assign sum12   = {1'b0, aw[11:0]} + {1'b0, bw[11:0]};

  // daa adjust, decided on the original accumulator
  always_comb begin
    if (in_q.subtract_in) begin
      daa_hi = in_q.carry_in;
      daa_lo = in_q.half_in;
    end else begin
      daa_hi = in_q.carry_in | (a8 > cpu_alu_pkg::DAA_HI_LIM);
      daa_lo = in_q.half_in | (a8[3:0] > cpu_alu_pkg::DAA_LO_LIM);
    end
    daa_adj = (daa_hi ? cpu_alu_pkg::DAA_HI_ADJ : 8'h00)
            | (daa_lo ? cpu_alu_pkg::DAA_LO_ADJ : 8'h00);
  end

  always_comb begin
    r    = aw;
    z    = in_q.zero_in;
    n    = in_q.subtract_in;
    h    = in_q.half_in;
    c    = in_q.carry_in;
    setz = 1'b0;
    case (cpu_alu_pkg::alu_op_t'(in_q.op))
      cpu_alu_pkg::OP_ADD, cpu_alu_pkg::OP_ADC: begin
        r = {8'd0, sum9[7:0]}; h = sum_lo[4]; c = sum9[8]; n = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_SUB, cpu_alu_pkg::OP_SBC: begin
        r = {8'd0, diff9[7:0]}; h = diff_lo[4]; c = diff9[8]; n = 1'b1; setz = 1'b1;
      end
      cpu_alu_pkg::OP_CP: begin
        r = {8'd0, a8}; h = diff_lo[4]; c = diff9[8]; n = 1'b1;
        z = (diff9[7:0] == 8'd0);
      end
      cpu_alu_pkg::OP_AND: begin
        r = {8'd0, a8 & b8}; n = 1'b0; h = 1'b1; c = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_XOR: begin
        r = {8'd0, a8 ^ b8}; n = 1'b0; h = 1'b0; c = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_OR: begin
        r = {8'd0, a8 | b8}; n = 1'b0; h = 1'b0; c = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_INC: begin
        r = {8'd0, inc8}; n = 1'b0; h = (inc8[3:0] == 4'h0); setz = 1'b1;
      end
      cpu_alu_pkg::OP_DEC: begin
        r = {8'd0, dec8}; n = 1'b1; h = (dec8[3:0] == 4'hF); setz = 1'b1;
      end
      cpu_alu_pkg::OP_RLC: begin
        r = {8'd0, a8[6:0], a8[7]}; c = a8[7]; n = 1'b0; h = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_RRC: begin
        r = {8'd0, a8[0], a8[7:1]}; c = a8[0]; n = 1'b0; h = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_RL: begin
        r = {8'd0, a8[6:0], in_q.carry_in}; c = a8[7]; n = 1'b0; h = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_RR: begin
        r = {8'd0, in_q.carry_in, a8[7:1]}; c = a8[0]; n = 1'b0; h = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_SLA: begin
        r = {8'd0, a8[6:0], 1'b0}; c = a8[7]; n = 1'b0; h = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_SRA: begin
        r = {8'd0, a8[7], a8[7:1]}; c = a8[0]; n = 1'b0; h = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_SRL: begin
        r = {8'd0, 1'b0, a8[7:1]}; c = a8[0]; n = 1'b0; h = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_SWAP: begin
        r = {8'd0, a8[3:0], a8[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_DAA: begin
        if (in_q.subtract_in) begin
          r = {8'd0, a8 - daa_adj};
        end else begin
          r = {8'd0, a8 + daa_adj};
          c = daa_hi;
        end
        h = 1'b0; setz = 1'b1;
      end
      cpu_alu_pkg::OP_CPL: begin
        r = {8'd0, ~a8}; n = 1'b1; h = 1'b1;
      end
      cpu_alu_pkg::OP_SCF: begin
        r = {8'd0, a8}; n = 1'b0; h = 1'b0; c = 1'b1;
      end
      cpu_alu_pkg::OP_CCF: begin
        r = {8'd0, a8}; n = 1'b0; h = 1'b0; c = ~in_q.carry_in;
      end
      cpu_alu_pkg::OP_BIT: begin
        r = {8'd0, a8}; z = ((a8 & b8) == 8'd0); n = 1'b0; h = 1'b1;
      end
      cpu_alu_pkg::OP_SET: begin
        r = {8'd0, a8 | b8};
      end
      cpu_alu_pkg::OP_RES: begin
        r = {8'd0, a8 & ~b8};
      end
      cpu_alu_pkg::OP_ADD16: begin
        r = sum17[15:0]; h = sum12[12]; c = sum17[16]; n = 1'b0;
      end
      cpu_alu_pkg::OP_ADDSP: begin
        r = aw + {{8{b8[7]}}, b8}; h = sum_lo[4]; c = sum9[8]; z = 1'b0; n = 1'b0;
      end
      cpu_alu_pkg::OP_INC16: begin
        r = aw + 16'd1;
      end
      cpu_alu_pkg::OP_DEC16: begin
        r = aw - 16'd1;
      end
      default: begin
        r = aw;
      end
    endcase
    if (setz) begin
      z = (r == 16'd0);
    end
    outcome_next.result       = r;
    outcome_next.zero_out     = z;
    outcome_next.subtract_out = n;
    outcome_next.half_out     = h;
    outcome_next.carry_out    = c;
  end

endmodule
`default_nettype wire

/* src/cpu_alu_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_chk
// Port-level checks for the CPU ALU: latency, beat count and a few flag rules.
// ----------------------------------------------------------------------------
module cpu_alu_chk (
  input wire                   clk,
  input wire                   rst,
  input wire                   start,
  input wire                   busy,
  input wire cpu_alu_pkg::alu_in_t  operation,
  input wire                   done,
  input wire cpu_alu_pkg::alu_out_t outcome
);

  // never stalls the issuing side
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every accepted beat yields a result with done high
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result missing");

  // no result without an accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("unexpected result");

  // scf always sets carry and clears n and h
  a_scf: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation.op == cpu_alu_pkg::OP_SCF) |->
      ##2 (outcome.carry_out && !outcome.subtract_out && !outcome.half_out))
    else $error("scf flags wrong");

  // logical and always sets half and clears carry
  a_and: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation.op == cpu_alu_pkg::OP_AND) |->
      ##2 (outcome.half_out && !outcome.carry_out && outcome.result[15:8] == 8'd0))
    else $error("and flags wrong");

endmodule

bind cpu_alu_with_flags cpu_alu_chk u_cpu_alu_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .done      (done),
  .outcome   (outcome)
);
`default_nettype wire

/* verif/cpu_alu_with_flags_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_tb
// Self-checking bench for the CPU ALU with flags. A short table of directed
// operations covers every op code, the last unused code, carry and borrow
// extremes and both daa directions. Random operations follow, and each one
// is checked against a behavioral model of the ALU kept in this file. The
// sender idles in random bursts. Every result is compared field by field, in
// order, against the oldest pending expectation.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_tb;
  import cpu_alu_pkg::*;

  localparam int          RANDOM_OPS     = 400;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [4:0]  OP_UNUSED_LAST = 5'd31;

  typedef struct packed {
    logic [4:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    logic [3:0]  znhc;
    logic        pinned;
    logic [15:0] result;
    logic [3:0]  znhc_out;
  } op_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  alu_in_t  operation;
  logic     done;
  alu_out_t outcome;

  alu_out_t    pending_outcomes[$];
  int          mismatches;
  int          results_checked;
  int          beats_sent;
  int          idle_cycles;
  int          burst_left;
  logic [31:0] ops_hit;
  op_row_t     directed_ops [34];

  cpu_alu_with_flags dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .done      (done),
    .outcome   (outcome)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alu_out_t alu_outcome_of(alu_in_t beat);
    alu_out_t   res;
    logic [7:0] a, b, r8, adj;
    logic [15:0] r16;
    logic [4:0] sum5;
    logic [8:0] sum9;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic       z, n, h, c, cin, set_zero;
    a        = beat.operand_a[7:0];
    b        = beat.operand_b[7:0];
    z        = beat.zero_in;
    n        = beat.subtract_in;
    h        = beat.half_in;
    c        = beat.carry_in;
    r8       = a;
    r16      = beat.operand_a;
    set_zero = 1'b0;
    adj      = 8'h00;
    case (beat.op)
      OP_ADD, OP_ADC: begin
        cin      = (beat.op == OP_ADC) ? c : 1'b0;
        sum5     = a[3:0] + b[3:0] + cin;
        sum9     = a + b + cin;
        h        = sum5[4];
        c        = sum9[8];
        r8       = sum9[7:0];
        n        = 1'b0;
        set_zero = 1'b1;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // borrows show up as the sign bit of the widened difference
        cin      = (beat.op == OP_SBC) ? c : 1'b0;
        sum5     = a[3:0] - b[3:0] - cin;
        sum9     = a - b - cin;
        h        = sum5[4];
        c        = sum9[8];
        r8       = sum9[7:0];
        n        = 1'b1;
        set_zero = 1'b1;
        if (beat.op == OP_CP) begin
          z        = (r8 == 8'h00);
          r8       = a;
          set_zero = 1'b0;
        end
      end
      OP_AND: begin r8 = a & b; n = 1'b0; h = 1'b1; c = 1'b0; set_zero = 1'b1; end
      OP_XOR: begin r8 = a ^ b; n = 1'b0; h = 1'b0; c = 1'b0; set_zero = 1'b1; end
      OP_OR:  begin r8 = a | b; n = 1'b0; h = 1'b0; c = 1'b0; set_zero = 1'b1; end
      OP_INC: begin
        r8 = a + 8'd1; n = 1'b0; h = (r8[3:0] == 4'h0); set_zero = 1'b1;
      end
      OP_DEC: begin
        r8 = a - 8'd1; n = 1'b1; h = (r8[3:0] == 4'hF); set_zero = 1'b1;
      end
      OP_RLC: begin r8 = {a[6:0], a[7]}; c = a[7]; n = 1'b0; h = 1'b0; set_zero = 1'b1; end
      OP_RRC: begin r8 = {a[0], a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0; set_zero = 1'b1; end
      OP_RL:  begin r8 = {a[6:0], c};    c = a[7]; n = 1'b0; h = 1'b0; set_zero = 1'b1; end
      OP_RR:  begin r8 = {c, a[7:1]};    c = a[0]; n = 1'b0; h = 1'b0; set_zero = 1'b1; end
      OP_SLA: begin r8 = {a[6:0], 1'b0}; c = a[7]; n = 1'b0; h = 1'b0; set_zero = 1'b1; end
      OP_SRA: begin r8 = {a[7], a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0; set_zero = 1'b1; end
      OP_SRL: begin r8 = {1'b0, a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0; set_zero = 1'b1; end
      OP_SWAP: begin
        r8 = {a[3:0], a[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0; set_zero = 1'b1;
      end
      OP_DAA: begin
        if (n) begin
          if (c) adj = adj + DAA_HI_ADJ;
          if (h) adj = adj + DAA_LO_ADJ;
          r8 = a - adj;
        end else begin
          if (c || a > DAA_HI_LIM) begin
            adj = adj + DAA_HI_ADJ;
            c   = 1'b1;
          end
          if (h || a[3:0] > DAA_LO_LIM) adj = adj + DAA_LO_ADJ;
          r8 = a + adj;
        end
        h        = 1'b0;
        set_zero = 1'b1;
      end
      OP_CPL: begin r8 = ~a; n = 1'b1; h = 1'b1; end
      OP_SCF: begin n = 1'b0; h = 1'b0; c = 1'b1; end
      OP_CCF: begin n = 1'b0; h = 1'b0; c = ~c; end
      OP_BIT: begin z = ((a & b) == 8'h00); n = 1'b0; h = 1'b1; end
      OP_SET: r8 = a | b;
      OP_RES: r8 = a & ~b;
      OP_ADD16: begin
        sum13 = beat.operand_a[11:0] + beat.operand_b[11:0];
        sum17 = beat.operand_a + beat.operand_b;
        h     = sum13[12];
        c     = sum17[16];
        r16   = sum17[15:0];
        n     = 1'b0;
      end
      OP_ADDSP: begin
        sum5 = beat.operand_a[3:0] + b[3:0];
        sum9 = beat.operand_a[7:0] + b;
        h    = sum5[4];
        c    = sum9[8];
        r16  = beat.operand_a + {{8{b[7]}}, b};
        z    = 1'b0;
        n    = 1'b0;
      end
      OP_INC16: r16 = beat.operand_a + 16'd1;
      OP_DEC16: r16 = beat.operand_a - 16'd1;
      default:  r16 = beat.operand_a;
    endcase
    // byte ops come back zero-extended
    if (beat.op <= OP_RES) r16 = {8'h00, r8};
    if (set_zero) z = (r16 == 16'h0000);
    res.result       = r16;
    res.zero_out     = z;
    res.subtract_out = n;
    res.half_out     = h;
    res.carry_out    = c;
    return res;
  endfunction

  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      2:       v = {8'h00, 8'($urandom)};
      3:       v = {8'($urandom), 8'(16 * $urandom_range(0, 9) + $urandom_range(0, 9))};
      4:       v = {8'($urandom), 8'h80 | 8'($urandom_range(0, 1))};
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_op(input alu_in_t beat, input logic pinned, input alu_out_t pinned_out);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left = burst_left - 1;
    operation <= beat;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(pinned ? pinned_out : alu_outcome_of(beat));
    ops_hit[beat.op] = 1'b1;
    beats_sent++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    alu_out_t oldest;
    if ((!rst && start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing pending: result %h", outcome.result);
        mismatches++;
      end else begin
        oldest = pending_outcomes.pop_front();
        check_field("result", oldest.result, outcome.result);
        check_field("zero_out", 16'(oldest.zero_out), 16'(outcome.zero_out));
        check_field("subtract_out", 16'(oldest.subtract_out), 16'(outcome.subtract_out));
        check_field("half_out", 16'(oldest.half_out), 16'(outcome.half_out));
        check_field("carry_out", 16'(oldest.carry_out), 16'(outcome.carry_out));
        results_checked++;
      end
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL cpu_alu_with_flags");
    $finish;
  end

  initial begin
    alu_in_t  beat;
    alu_out_t pinned_out;
    rst             = 1'b1;
    start           = 1'b0;
    operation       = '0;
    mismatches      = 0;
    results_checked = 0;
    beats_sent      = 0;
    idle_cycles     = 0;
    burst_left      = 0;
    ops_hit         = '0;
    // op, a, b, znhc in, pinned, result, znhc out
    directed_ops = '{
      '{OP_ADD,   16'h12FF, 16'h3401, 4'b0100, 1'b1, 16'h0000, 4'b1011},
      '{OP_ADC,   16'h000F, 16'h0000, 4'b0001, 1'b0, 16'h0000, 4'b0000},
      '{OP_SUB,   16'hAB00, 16'hCD01, 4'b0000, 1'b1, 16'h00FF, 4'b0111},
      '{OP_SBC,   16'h0010, 16'h000F, 4'b0001, 1'b0, 16'h0000, 4'b0000},
      '{OP_SBC,   16'h00FF, 16'h00FF, 4'b0001, 1'b0, 16'h0000, 4'b0000},
      '{OP_AND,   16'hFFAA, 16'hFF55, 4'b0001, 1'b1, 16'h0000, 4'b1010},
      '{OP_XOR,   16'h00FF, 16'h00FF, 4'b1111, 1'b1, 16'h0000, 4'b1000},
      '{OP_OR,    16'h0000, 16'hFF80, 4'b1111, 1'b0, 16'h0000, 4'b0000},
      '{OP_CP,    16'h1242, 16'h0042, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_INC,   16'h00FF, 16'h0000, 4'b0001, 1'b1, 16'h0000, 4'b1011},
      '{OP_DEC,   16'h0000, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_RLC,   16'h0080, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_RRC,   16'h0001, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_RL,    16'h0080, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_RR,    16'h0001, 16'h0000, 4'b0001, 1'b0, 16'h0000, 4'b0000},
      '{OP_SLA,   16'h00FF, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_SRA,   16'h0081, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_SRL,   16'h0001, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_SWAP,  16'h00F0, 16'h0000, 4'b0001, 1'b0, 16'h0000, 4'b0000},
      '{OP_DAA,   16'h009A, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_DAA,   16'h0000, 16'h0000, 4'b0111, 1'b0, 16'h0000, 4'b0000},
      '{OP_CPL,   16'h005A, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_SCF,   16'h0033, 16'h0000, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_CCF,   16'h0033, 16'h0000, 4'b0001, 1'b0, 16'h0000, 4'b0000},
      '{OP_BIT,   16'h0080, 16'h0080, 4'b1001, 1'b0, 16'h0000, 4'b0000},
      '{OP_SET,   16'h0001, 16'hFF80, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_RES,   16'h00FF, 16'hFF0F, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_ADD16, 16'hFFFF, 16'h0001, 4'b1100, 1'b1, 16'h0000, 4'b1011},
      '{OP_ADD16, 16'h0FFF, 16'h0001, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_ADDSP, 16'hFFF8, 16'h0008, 4'b1100, 1'b0, 16'h0000, 4'b0000},
      '{OP_ADDSP, 16'h0000, 16'hFF80, 4'b0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_INC16, 16'hFFFF, 16'h1234, 4'b1010, 1'b1, 16'h0000, 4'b1010},
      '{OP_DEC16, 16'h0000, 16'hFFFF, 4'b0101, 1'b1, 16'hFFFF, 4'b0101},
      '{OP_UNUSED_LAST, 16'hBEEF, 16'h1234, 4'b1011, 1'b1, 16'hBEEF, 4'b1011}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ops[i]) begin
      beat.op        = directed_ops[i].op;
      beat.operand_a = directed_ops[i].a;
      beat.operand_b = directed_ops[i].b;
      {beat.zero_in, beat.subtract_in, beat.half_in, beat.carry_in} = directed_ops[i].znhc;
      pinned_out.result = directed_ops[i].result;
      {pinned_out.zero_out, pinned_out.subtract_out, pinned_out.half_out,
       pinned_out.carry_out} = directed_ops[i].znhc_out;
      send_op(beat, directed_ops[i].pinned, pinned_out);
    end

    for (int i = 0; i < RANDOM_OPS; i++) begin
      beat.op        = 5'($urandom);
      beat.operand_a = pick_operand();
      beat.operand_b = pick_operand();
      {beat.zero_in, beat.subtract_in, beat.half_in, beat.carry_in} = 4'($urandom);
      send_op(beat, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d op beats sent over %0d distinct op codes, %0d results checked",
             beats_sent, $countones(ops_hit), results_checked);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS cpu_alu_with_flags");
    end else begin
      $display("FAIL cpu_alu_with_flags");
    end
    $finish;
  end

endmodule
